>>> sv/kmd_pkg.sv
// kmd_pkg: field widths, key tables and the symbol-shift remap for the
// keyboard matrix decoder. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package kmd_pkg;

  localparam int unsigned ColW  = 5;
  localparam int unsigned RowN  = 8;
  localparam int unsigned CodeW = 8;
  localparam int unsigned JoyN  = 5;

  typedef logic [ColW-1:0]  cols_t;
  typedef logic [CodeW-1:0] code_t;
  typedef logic [2:0]       row_idx_t;
  typedef logic [6:0]       rom_idx_t;

  localparam code_t NoKey      = 8'h00;
  localparam code_t CapsSymCode = 8'h87;

  // rows in scan order: 0, 7, then 1 to 6
  localparam row_idx_t SCAN_ROW [RowN] = '{3'd0, 3'd7, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6};

  localparam code_t JOY_CODE [JoyN] = '{8'h09, 8'h08, 8'h0a, 8'h0b, 8'h0d};

  // index is {caps, column, row}
  localparam code_t KEY_ROM [128] = '{
    8'h00, 8'h61, 8'h71, 8'h31, 8'h30, 8'h70, 8'h0d, 8'h20,
    8'h7a, 8'h73, 8'h77, 8'h32, 8'h39, 8'h6f, 8'h6c, 8'h00,
    8'h78, 8'h64, 8'h65, 8'h33, 8'h38, 8'h69, 8'h6b, 8'h6d,
    8'h63, 8'h66, 8'h72, 8'h34, 8'h37, 8'h75, 8'h6a, 8'h6e,
    8'h76, 8'h67, 8'h74, 8'h35, 8'h36, 8'h79, 8'h68, 8'h62,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h41, 8'h51, 8'h00, 8'h0c, 8'h50, 8'h0d, 8'h20,
    8'h5a, 8'h53, 8'h57, 8'h00, 8'h87, 8'h4f, 8'h4c, 8'h00,
    8'h58, 8'h44, 8'h45, 8'h00, 8'h09, 8'h49, 8'h4b, 8'h4d,
    8'h43, 8'h46, 8'h52, 8'h00, 8'h0b, 8'h55, 8'h4a, 8'h4e,
    8'h56, 8'h47, 8'h54, 8'h08, 8'h0a, 8'h59, 8'h48, 8'h42,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // symbol-shift remap of lower-case keys
  function automatic code_t symbol_map(code_t c);
    code_t r;
    unique case (c)
      8'h6d:   r = 8'h2e;
      8'h76:   r = 8'h2f;
      8'h61:   r = 8'h81;
      8'h62:   r = 8'h82;
      8'h63:   r = 8'h83;
      8'h64:   r = 8'h84;
      8'h75:   r = 8'h85;
      8'h72:   r = 8'h86;
      default: r = NoKey;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/kmd_if.sv
// kmd_in_if and kmd_out_if: valid/ready channels for matrix snapshots and
// key codes. Depends on kmd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface kmd_in_if;
  import kmd_pkg::*;

  logic  valid;
  logic  ready;
  cols_t joy_lines;
  cols_t row0_keys;
  cols_t row1_keys;
  cols_t row2_keys;
  cols_t row3_keys;
  cols_t row4_keys;
  cols_t row5_keys;
  cols_t row6_keys;
  cols_t row7_keys;

  modport source (
    output valid, joy_lines, row0_keys, row1_keys, row2_keys, row3_keys,
           row4_keys, row5_keys, row6_keys, row7_keys,
    input  ready
  );
  modport sink (
    input  valid, joy_lines, row0_keys, row1_keys, row2_keys, row3_keys,
           row4_keys, row5_keys, row6_keys, row7_keys,
    output ready
  );
endinterface

interface kmd_out_if;
  import kmd_pkg::*;

  logic  valid;
  logic  ready;
  code_t key_code;

  modport source (output valid, key_code, input ready);
  modport sink (input valid, key_code, output ready);
endinterface

`default_nettype wire

>>> sv/keyboard_matrix_decoder.sv
// Keyboard matrix decoder: one 8x5 key matrix snapshot plus joystick lines
// in, one key code out. Depends on kmd_pkg and kmd_if.
//
// Each snapshot transfer is captured in an input register, decoded by a short
// priority search and table lookup, and the key code lands in a result
// register behind it. A new snapshot is taken every cycle while in_i.ready
// is high; the input and result registers form a two-deep pipeline, so
// input ready drops only when both hold items and the result is not taken.
// joystick_enable (reset 1) is written through cfg_we_i / cfg_wdata_i; the
// user must do so only while the block is idle, the block has no such check.
`timescale 1ns / 1ps
`default_nettype none

module keyboard_matrix_decoder (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  cfg_we_i,
  input  wire logic  cfg_wdata_i,
  kmd_in_if.sink     in_i,
  kmd_out_if.source  out_o
);
  import kmd_pkg::*;

  logic  joy_en_q;
  logic  s1_valid_q;
  cols_t joy_q;
  cols_t rows_q [RowN];
  logic  out_valid_q;
  code_t key_code_q;
  code_t key_code_d;
  logic  out_adv;
  logic  s1_adv;

  assign out_adv    = !out_valid_q || out_o.ready;
  assign s1_adv     = !s1_valid_q || out_adv;
  assign in_i.ready = s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      joy_en_q <= 1'b1;
    end else if (cfg_we_i) begin
      joy_en_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_adv) s1_valid_q <= in_i.valid;
      if (out_adv) out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && s1_adv) begin
      joy_q     <= in_i.joy_lines;
      rows_q[0] <= in_i.row0_keys;
      rows_q[1] <= in_i.row1_keys;
      rows_q[2] <= in_i.row2_keys;
      rows_q[3] <= in_i.row3_keys;
      rows_q[4] <= in_i.row4_keys;
      rows_q[5] <= in_i.row5_keys;
      rows_q[6] <= in_i.row6_keys;
      rows_q[7] <= in_i.row7_keys;
    end
    if (s1_valid_q && out_adv) key_code_q <= key_code_d;
  end

  // decode
  always_comb begin
    cols_t    scan_keys [RowN];
    logic     caps;
    logic     sym;
    logic     found;
    row_idx_t hit_row;
    cols_t    hit_keys;
    logic [2:0] hit_col;
    code_t    joy_code;
    code_t    rom_code;

    caps = !rows_q[0][0];
    sym  = !rows_q[7][1];
    scan_keys[0] = ~rows_q[0] & 5'h1e;
    scan_keys[1] = ~rows_q[7] & 5'h1d;
    for (int i = 2; i < RowN; i++) begin
      scan_keys[i] = ~rows_q[i-1];
    end

    found    = 1'b0;
    hit_row  = '0;
    hit_keys = '0;
    for (int i = 0; i < RowN; i++) begin
      if (!found && scan_keys[i] != '0) begin
        found    = 1'b1;
        hit_row  = SCAN_ROW[i];
        hit_keys = scan_keys[i];
      end
    end

    hit_col = '0;
    for (int b = ColW - 1; b >= 0; b--) begin
      if (hit_keys[b]) hit_col = 3'(b);
    end

    joy_code = NoKey;
    for (int b = JoyN - 1; b >= 0; b--) begin
      if (joy_q[b]) joy_code = JOY_CODE[b];
    end

    rom_code = KEY_ROM[{caps, hit_col, hit_row}];

    priority if (joy_en_q && joy_q != '0) begin
      key_code_d = joy_code;
    end else if (!found) begin
      key_code_d = NoKey;
    end else if (sym && caps) begin
      key_code_d = CapsSymCode;
    end else if (sym) begin
      key_code_d = symbol_map(rom_code);
    end else begin
      key_code_d = rom_code;
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.key_code = key_code_q;

endmodule

`default_nettype wire

>>> sv/kmd_checker.sv
// kmd_checker: port-level checks on the keyboard matrix decoder, bound to
// keyboard_matrix_decoder below. Depends on kmd_pkg and kmd_if.
`timescale 1ns / 1ps
`default_nettype none

module kmd_checker (
  input wire logic           clk_i,
  input wire logic           rst_ni,
  input wire logic           in_valid_i,
  input wire logic           in_ready_i,
  input wire logic           out_valid_i,
  input wire logic           out_ready_i,
  input wire kmd_pkg::code_t key_code_i
);
  import kmd_pkg::*;

  // no result shown right after a reset edge
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("result valid during reset");

  // input stalls only behind a held result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with empty output");

  // stalled result stays
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(key_code_i))
    else $error("stalled result dropped or changed");

  // a transfer while no result is shown is followed by a valid result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && !out_valid_i |=> ##1 out_valid_i)
    else $error("accepted snapshot gave no result");

endmodule

bind keyboard_matrix_decoder kmd_checker u_kmd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .key_code_i  (out_o.key_code)
);

`default_nettype wire
